[rtl/axtr_pkg.sv]
`default_nettype none
package axtr_pkg;

  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_CMD    = 8'hC0;
  localparam logic [7:0] BYTE_ACK    = 8'h06;
  localparam logic [7:0] BYTE_NAK    = 8'h15;
  localparam logic [7:0] NODE_RESET  = 8'h14;
  localparam logic [7:0] SENDER_RESET = 8'h24;

  localparam logic [7:0] REG_NODE_ADDRESS   = 8'd0;
  localparam logic [7:0] REG_SENDER_ADDRESS = 8'd1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR_BEGUN,
    PH_ADDRESSED,
    PH_COMMAND,
    PH_SENDER,
    PH_LENGTH,
    PH_TELEGRAM,
    PH_CHECK
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ADDR_ACK,
    KIND_ACCEPT,
    KIND_NAK,
    KIND_BYTE
  } kind_e;

  typedef struct packed {
    logic       rx_backlog;
    logic       rx_mark;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       valid;
    kind_e      out_kind;
    logic [7:0] out_byte;
    logic [7:0] out_index;
    logic       out_last;
  } result_t;

endpackage
`default_nettype wire

[rtl/axtr_phase_fsm.sv]
`default_nettype none
module axtr_phase_fsm (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire axtr_pkg::item_t item_i,
  input  wire logic [7:0]      node_address_i,
  input  wire logic [7:0]      sender_address_i,
  output axtr_pkg::phase_e     phase_o,
  output axtr_pkg::result_t    result_o
);
  import axtr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] count_q, count_d;
  logic [7:0] len_q, len_d;
  logic       last;

  always_comb begin
    phase_d  = phase_q;
    xor_d    = xor_q;
    count_d  = count_q;
    len_d    = len_q;
    result_o = '0;
    last     = (count_q == len_q);
    case (phase_q)
      PH_IDLE: begin
        if (item_i.rx_byte == BYTE_ZERO && item_i.rx_mark) phase_d = PH_ADDR_BEGUN;
      end
      PH_ADDR_BEGUN: begin
        if (item_i.rx_byte == node_address_i && item_i.rx_mark) begin
          // backlog keeps the line free: skip the address ACK
          if (!item_i.rx_backlog) begin
            result_o.valid    = 1'b1;
            result_o.out_kind = KIND_ADDR_ACK;
            result_o.out_byte = BYTE_ACK;
          end
          phase_d = PH_ADDRESSED;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_ADDRESSED: begin
        if (item_i.rx_byte == BYTE_CMD && !item_i.rx_mark) begin
          xor_d   = item_i.rx_byte;
          phase_d = PH_COMMAND;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_COMMAND: begin
        if (item_i.rx_byte == BYTE_ZERO && !item_i.rx_mark) begin
          xor_d   = xor_q ^ item_i.rx_byte;
          phase_d = PH_SENDER;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_SENDER: begin
        // mark bit ignored on the sender byte
        if (item_i.rx_byte == sender_address_i) begin
          xor_d   = xor_q ^ item_i.rx_byte;
          phase_d = PH_LENGTH;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_LENGTH: begin
        if (item_i.rx_byte != BYTE_ZERO && !item_i.rx_mark) begin
          len_d             = item_i.rx_byte;
          xor_d             = xor_q ^ item_i.rx_byte;
          count_d           = 8'd1;
          result_o.valid    = 1'b1;
          result_o.out_kind = KIND_BYTE;
          result_o.out_byte = item_i.rx_byte;
          phase_d           = PH_TELEGRAM;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_TELEGRAM: begin
        xor_d              = xor_q ^ item_i.rx_byte;
        result_o.valid     = 1'b1;
        result_o.out_kind  = KIND_BYTE;
        result_o.out_byte  = item_i.rx_byte;
        result_o.out_index = count_q;
        result_o.out_last  = last;
        count_d            = count_q + 8'd1;
        if (last) phase_d = PH_CHECK;
      end
      PH_CHECK: begin
        result_o.valid = 1'b1;
        if (item_i.rx_byte == xor_q) begin
          result_o.out_kind = KIND_ACCEPT;
          result_o.out_byte = BYTE_ACK;
        end else begin
          result_o.out_kind = KIND_NAK;
          result_o.out_byte = BYTE_NAK;
        end
        phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
    if (!en_i) result_o.valid = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      xor_q   <= '0;
      count_q <= '0;
      len_q   <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      count_q <= count_d;
      len_q   <= len_d;
    end
  end

  assign phase_o = phase_q;

endmodule
`default_nettype wire

[rtl/axtr_out_reg.sv]
`default_nettype none
module axtr_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire axtr_pkg::result_t result_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              take_i,
  output axtr_pkg::result_t      result_o
);
  import axtr_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) valid_d = 1'b0;
    if (ready_o && result_i.valid) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload: load only with a new result
  always_ff @(posedge clk_i) begin
    if (ready_o && result_i.valid) data_q <= result_i;
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule
`default_nettype wire

[rtl/addressed_xor_telegram_receiver_core.sv]
// Path: a character is loaded into the input register, passes through the phase machine,
// and its result is loaded into the result register that drives the master side.
// Throughput: one character per cycle while the master side takes results; the phase
// register and its next-state logic close the loop from one character to the next.
// Reset (rst_ni low, asynchronous): phase idle, checksum, count and length cleared,
// both pipeline stages empty, node address 0x14 and sender address 0x24.
`default_nettype none
module addressed_xor_telegram_receiver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // character input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] rx_backlog, rest zero
  input  wire logic [0:0]  s_axis_tuser,   // [0] rx_mark
  // result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [15:8] out_index
  output logic [1:0]       m_axis_tuser,   // [1:0] out_kind
  output logic             m_axis_tlast,   // out_last
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  import axtr_pkg::*;

  logic       in_valid_q;
  item_t      in_item_q;
  logic       advance;
  logic       out_ready;
  logic [7:0] node_q;
  logic [7:0] sender_q;
  phase_e     phase;
  result_t    step_res;
  result_t    out_res;

  // Configuration: always ready, writes beyond the register list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q   <= NODE_RESET;
      sender_q <= SENDER_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_NODE_ADDRESS)   node_q   <= cfg_data_i;
      if (cfg_index_i == REG_SENDER_ADDRESS) sender_q <= cfg_data_i;
    end
  end

  // Input register: advance the held character into the phase machine whenever
  // the result register can take whatever it produces.
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.rx_byte    <= s_axis_tdata[7:0];
      in_item_q.rx_backlog <= s_axis_tdata[8];
      in_item_q.rx_mark    <= s_axis_tuser[0];
    end
  end

  // Receive machine: phase, running checksum, byte count and length.
  axtr_phase_fsm u_fsm (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (advance),
    .item_i           (in_item_q),
    .node_address_i   (node_q),
    .sender_address_i (sender_q),
    .phase_o          (phase),
    .result_o         (step_res)
  );

  // Result register: holds one finished transfer until the master side takes it.
  axtr_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .result_i (step_res),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid),
    .take_i   (m_axis_tready),
    .result_o (out_res)
  );

  assign m_axis_tdata = {out_res.out_index, out_res.out_byte};
  assign m_axis_tuser = out_res.out_kind;
  assign m_axis_tlast = out_res.out_last;

  // A checksum character always produces an accept or reject transfer.
  a_check_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && phase == PH_CHECK) |=> m_axis_tvalid)
    else $error("checksum character produced no result");

  // Only telegram bytes past the length byte can carry the last flag.
  a_last_on_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tuser == KIND_BYTE && m_axis_tdata[15:8] != 8'd0))
    else $error("last flag on a non-payload result");

  // ACK and NAK transfers carry index zero and the matching reply byte.
  a_reply_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_BYTE) |->
      (m_axis_tdata[15:8] == 8'd0 &&
       ((m_axis_tuser == KIND_NAK && m_axis_tdata[7:0] == BYTE_NAK) ||
        (m_axis_tuser != KIND_NAK && m_axis_tdata[7:0] == BYTE_ACK))))
    else $error("malformed reply transfer");

  // The input stage never drops a held character while the result side stalls.
  a_hold_in_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_ready) |=> in_valid_q)
    else $error("held character lost during stall");

endmodule
`default_nettype wire

[tb/tb_addressed_xor_telegram_receiver_core.sv]
`default_nettype none
module tb_addressed_xor_telegram_receiver_core;
  timeunit 1ns;
  timeprecision 1ps;

  import axtr_pkg::*;

  // Indexes beyond the register file; writes to them must leave both addresses alone.
  localparam logic [7:0] REG_FIRST_UNUSED = 8'd2;
  localparam logic [7:0] REG_LAST_UNUSED  = 8'hFF;

  // Cycles to let the two-stage pipeline empty before a register write or the end.
  localparam int unsigned SETTLE_CYCLES = 6;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned STALL_LIMIT   = 2000;
  // Random characters per idling pattern.
  localparam int unsigned CHARS_PER_PHASE = 520;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] pos;
    logic       last;
  } reply_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i  = '0;

  addressed_xor_telegram_receiver_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte, [8] rx_backlog, rest zero
    .s_axis_tuser  (s_axis_tuser),   // [0] rx_mark
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte, [15:8] out_index
    .m_axis_tuser  (m_axis_tuser),   // [1:0] out_kind
    .m_axis_tlast  (m_axis_tlast),   // out_last
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Characters waiting to be driven, and replies the receive machine owes us.
  item_t       pending_chars[$];
  reply_t      expected_replies[$];
  int unsigned chars_queued = 0;
  int unsigned err_count    = 0;
  int unsigned stall_cycles = 0;

  // Percent of cycles in which each side holds off.
  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 60;

  // Shadow of the receive machine: its registers and its working state.
  logic [7:0]  node_addr_q   = NODE_RESET;
  logic [7:0]  sender_addr_q = SENDER_RESET;
  phase_e      rx_phase      = PH_IDLE;
  logic [7:0]  chk_xor       = '0;
  logic [7:0]  pos_count     = '0;
  logic [7:0]  tel_len       = '0;

  task automatic owe_reply(input kind_e kind, input logic [7:0] data, input logic [7:0] pos,
                           input logic last);
    reply_t r;
    r.kind = kind;
    r.data = data;
    r.pos  = pos;
    r.last = last;
    expected_replies.push_back(r);
  endtask

  // Advance the shadow machine by one received character.
  task automatic absorb_char(input logic [7:0] b, input logic mark, input logic backlog);
    logic hit_last;
    hit_last = (pos_count == tel_len);
    case (rx_phase)
      PH_IDLE: begin
        // only a marked zero opens an address
        if (b == BYTE_ZERO && mark) rx_phase = PH_ADDR_BEGUN;
      end
      PH_ADDR_BEGUN: begin
        if (b == node_addr_q && mark) begin
          // a waiting backlog suppresses the address ACK but not the advance
          if (!backlog) owe_reply(KIND_ADDR_ACK, BYTE_ACK, 8'd0, 1'b0);
          rx_phase = PH_ADDRESSED;
        end else begin
          rx_phase = PH_IDLE;
        end
      end
      PH_ADDRESSED: begin
        if (b == BYTE_CMD && !mark) begin
          chk_xor  = b;
          rx_phase = PH_COMMAND;
        end else begin
          rx_phase = PH_IDLE;
        end
      end
      PH_COMMAND: begin
        if (b == BYTE_ZERO && !mark) begin
          chk_xor  = chk_xor ^ b;
          rx_phase = PH_SENDER;
        end else begin
          rx_phase = PH_IDLE;
        end
      end
      PH_SENDER: begin
        // the mark bit of the sender byte does not matter
        if (b == sender_addr_q) begin
          chk_xor  = chk_xor ^ b;
          rx_phase = PH_LENGTH;
        end else begin
          rx_phase = PH_IDLE;
        end
      end
      PH_LENGTH: begin
        if (b != BYTE_ZERO && !mark) begin
          tel_len   = b;
          chk_xor   = chk_xor ^ b;
          pos_count = 8'd1;
          owe_reply(KIND_BYTE, b, 8'd0, 1'b0);
          rx_phase  = PH_TELEGRAM;
        end else begin
          rx_phase = PH_IDLE;
        end
      end
      PH_TELEGRAM: begin
        // payload is taken as it comes; the count wraps after a full 255 run
        chk_xor = chk_xor ^ b;
        owe_reply(KIND_BYTE, b, pos_count, hit_last);
        pos_count = pos_count + 8'd1;
        if (hit_last) rx_phase = PH_CHECK;
      end
      default: begin
        if (b == chk_xor) owe_reply(KIND_ACCEPT, BYTE_ACK, 8'd0, 1'b0);
        else              owe_reply(KIND_NAK, BYTE_NAK, 8'd0, 1'b0);
        rx_phase = PH_IDLE;
      end
    endcase
  endtask

  // Driver: present the next pending character whenever the bus is free.
  always @(posedge clk_i or negedge rst_ni) begin : drive_chars
    item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        absorb_char(s_axis_tdata[7:0], s_axis_tuser[0], s_axis_tdata[8]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_chars.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, nxt.rx_backlog, nxt.rx_byte};
          s_axis_tuser  <= nxt.rx_mark;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every reply transfer against the oldest owed reply.
  always @(posedge clk_i or negedge rst_ni) begin : check_replies
    reply_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected reply: kind %0d byte %02h", m_axis_tuser, m_axis_tdata[7:0]);
          err_count++;
        end else begin
          want = expected_replies.pop_front();
          if (m_axis_tuser != want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            err_count++;
          end
          if (m_axis_tdata[7:0] != want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, m_axis_tdata[7:0]);
            err_count++;
          end
          if (m_axis_tdata[15:8] != want.pos) begin
            $error("out_index: expected %0d, got %0d", want.pos, m_axis_tdata[15:8]);
            err_count++;
          end
          if (m_axis_tlast != want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, m_axis_tlast);
            err_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_char(input logic [7:0] b, input logic mark, input logic backlog);
    item_t it;
    it.rx_byte    = b;
    it.rx_mark    = mark;
    it.rx_backlog = backlog;
    pending_chars.push_back(it);
    chars_queued++;
  endtask

  task automatic push_noise();
    logic [7:0] b;
    logic       mark;
    logic       backlog;
    b       = 8'($urandom);
    mark    = 1'($urandom_range(1));
    backlog = 1'($urandom_range(1));
    push_char(b, mark, backlog);
  endtask

  // Queue one telegram addressed to us. With spoil set, one header character or the
  // checksum is replaced by a random character; the checksum is also wrong at times.
  task automatic push_telegram(input int unsigned len, input bit spoil);
    logic [7:0]  hdr [6];
    logic [5:0]  hdr_mark;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic        mark;
    logic        backlog;
    int unsigned bad_at;
    hdr[0] = BYTE_ZERO;
    hdr[1] = node_addr_q;
    hdr[2] = BYTE_CMD;
    hdr[3] = BYTE_ZERO;
    hdr[4] = sender_addr_q;
    hdr[5] = len[7:0];
    hdr_mark    = 6'b000011;
    hdr_mark[4] = 1'($urandom_range(1));
    bad_at = spoil ? $urandom_range(6) : 7;
    sum = BYTE_CMD ^ sender_addr_q ^ len[7:0];
    for (int i = 0; i < 6; i++) begin
      if (i == bad_at) begin
        push_noise();
      end else begin
        // hold the backlog off the address most of the time so the ACK shows up
        backlog = (i == 1) ? ($urandom_range(9) < 3) : 1'($urandom_range(1));
        push_char(hdr[i], hdr_mark[i], backlog);
      end
    end
    for (int unsigned k = 0; k < len; k++) begin
      b       = 8'($urandom);
      mark    = 1'($urandom_range(1));
      backlog = 1'($urandom_range(1));
      sum     = sum ^ b;
      push_char(b, mark, backlog);
    end
    mark    = 1'($urandom_range(1));
    backlog = 1'($urandom_range(1));
    if (bad_at == 6) push_noise();
    else if ($urandom_range(9) < 2) push_char(sum ^ (8'd1 << $urandom_range(7)), mark, backlog);
    else push_char(sum, mark, backlog);
  endtask

  // Mostly clean short telegrams, some spoiled ones, some stray characters.
  task automatic push_random_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    stop_at = chars_queued + count;
    while (chars_queued < stop_at) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      if (pick < 70) begin
        push_telegram(len, 1'b0);
      end else if (pick < 85) begin
        push_telegram(len, 1'b1);
      end else begin
        repeat ($urandom_range(3, 1)) push_noise();
      end
    end
  endtask

  // Wait until every character is in, every reply is out and the pipeline is empty.
  task automatic drain_all();
    do @(posedge clk_i);
    while (pending_chars.size() != 0 || s_axis_tvalid || expected_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; call at a clock edge. Valid stays high for a following write.
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_NODE_ADDRESS) node_addr_q = val;
    else if (idx == REG_SENDER_ADDRESS) sender_addr_q = val;
  endtask

  initial begin : stimulus
    logic [7:0] junk;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stray characters in idle; unmarked zero must not open an address.
    push_char(BYTE_ZERO, 1'b0, 1'b0);
    push_char(8'h55, 1'b1, 1'b1);
    // Backlog on the address: no address ACK, marked sender byte, one payload byte,
    // correct checksum.
    push_char(BYTE_ZERO, 1'b1, 1'b0);
    push_char(node_addr_q, 1'b1, 1'b1);
    push_char(BYTE_CMD, 1'b0, 1'b0);
    push_char(BYTE_ZERO, 1'b0, 1'b0);
    push_char(sender_addr_q, 1'b1, 1'b0);
    push_char(8'd1, 1'b0, 1'b0);
    push_char(8'hFF, 1'b1, 1'b1);
    push_char(BYTE_CMD ^ sender_addr_q ^ 8'd1 ^ 8'hFF, 1'b0, 1'b0);
    // Address ACK, two payload bytes, wrong checksum gives a NAK.
    push_char(BYTE_ZERO, 1'b1, 1'b0);
    push_char(node_addr_q, 1'b1, 1'b0);
    push_char(BYTE_CMD, 1'b0, 1'b1);
    push_char(BYTE_ZERO, 1'b0, 1'b0);
    push_char(sender_addr_q, 1'b0, 1'b0);
    push_char(8'd2, 1'b0, 1'b0);
    push_char(8'h00, 1'b0, 1'b0);
    push_char(8'h80, 1'b1, 1'b0);
    push_char(8'h00, 1'b1, 1'b1);
    // Wrong command byte drops back to idle.
    push_char(BYTE_ZERO, 1'b1, 1'b0);
    push_char(node_addr_q, 1'b1, 1'b0);
    push_char(BYTE_CMD + 8'd1, 1'b0, 1'b0);
    // Zero length drops back to idle.
    push_telegram(0, 1'b0);
    drain_all();

    // Extremes of both addresses, plus a write to an index that does not exist.
    write_reg(REG_NODE_ADDRESS, 8'hFF);
    write_reg(REG_SENDER_ADDRESS, 8'h00);
    junk = 8'($urandom);
    write_reg(REG_FIRST_UNUSED, junk);
    cfg_valid_i <= 1'b0;

    // Sender idles lightly, receiver heavily; one full-length telegram first.
    push_telegram(255, 1'b0);
    push_random_traffic(CHARS_PER_PHASE - 262);
    drain_all();

    write_reg(REG_NODE_ADDRESS, 8'h00);
    write_reg(REG_SENDER_ADDRESS, 8'hFF);
    junk = 8'($urandom);
    write_reg(REG_LAST_UNUSED, junk);
    cfg_valid_i <= 1'b0;

    // Swap the idling pattern.
    send_idle_pct = 60;
    recv_idle_pct = 22;
    push_random_traffic(CHARS_PER_PHASE);
    drain_all();

    junk = 8'($urandom);
    write_reg(REG_NODE_ADDRESS, junk);
    junk = 8'($urandom);
    write_reg(REG_SENDER_ADDRESS, junk);
    junk = 8'($urandom_range(255, 2));
    write_reg(junk, 8'hA5);
    cfg_valid_i <= 1'b0;

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_telegram(255, 1'b0);
    push_random_traffic(CHARS_PER_PHASE - 262);
    drain_all();

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
rtl/axtr_pkg.sv
rtl/axtr_phase_fsm.sv
rtl/axtr_out_reg.sv
rtl/addressed_xor_telegram_receiver_core.sv
tb/tb_addressed_xor_telegram_receiver_core.sv
